/* rtl/core/emh_pkg.sv */
// ----------------------------------------------------------------------------
// Event min-heap package
// Field widths, operation and status codes, and the result record shared by
// the heap sequencer and the top level.
// ----------------------------------------------------------------------------
package emh_pkg;

  localparam int KEY_W    = 32;
  localparam int IN_TAG_W = 16;
  localparam int FILL_W   = 11;
  localparam int STATUS_W = 2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic [FILL_W-1:0]   fill;
    logic [STATUS_W-1:0] status;
    logic [IN_TAG_W-1:0] tag;
    logic [KEY_W-1:0]    time_key;
  } result_t;

endpackage

/* rtl/core/event_min_heap_unit.sv */
// ----------------------------------------------------------------------------
// Event min-heap unit
// Binary min-heap priority queue of timed events with a stream interface.
// ----------------------------------------------------------------------------
// Each request is an insert or a pop and yields exactly one result. The heap
// is walked one level at a time through a memory with registered reads, so
// every level takes a read state and a compare state. An insert climbs the new
// entry from the end of the heap until it reaches the root or stops below it.
// A pop moves the hole from the root down to the smaller child at each level;
// the last entry then either drops straight into the hole or climbs up from
// it until it reaches the root or stops below. A pop on a full heap of 1024
// entries descends nine levels. Errors (insert when full, pop when empty) go
// straight to the result without touching the memory. A new request is taken
// once the previous one has been handed to the output register, which holds
// the result until it is taken. The memory needs no clearing after reset.
module event_min_heap_unit #(
  parameter int HEAP_DEPTH = 1024,
  parameter int TAG_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // time_key[31:0], tag[47:32]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_time[31:0], out_tag[47:32], fill[58:48], zero
  output logic [1:0]  out_tuser   // status
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int SW = (TAG_BITS < emh_pkg::IN_TAG_W) ? TAG_BITS : emh_pkg::IN_TAG_W;
  localparam int EW = emh_pkg::KEY_W + SW;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [EW-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;
  emh_pkg::result_t res;

  emh_sequencer #(
    .DEPTH (HEAP_DEPTH),
    .AW    (AW),
    .CW    (CW),
    .SW    (SW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_kind     (in_tuser),
    .in_key      (in_tdata[31:0]),
    .in_tag      (in_tdata[47:32]),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b)
  );

  emh_heap_ram #(
    .DEPTH (HEAP_DEPTH),
    .AW    (AW),
    .EW    (EW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  assign out_tdata = {5'b0, res.fill, res.tag, res.time_key};
  assign out_tuser = res.status;

endmodule

/* rtl/core/emh_heap_ram.sv */
// ----------------------------------------------------------------------------
// Event min-heap entry memory
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module emh_heap_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int EW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [EW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [EW-1:0] rdata_a,
  output logic [EW-1:0] rdata_b
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* rtl/core/emh_sequencer.sv */
// ----------------------------------------------------------------------------
// Event min-heap sequencer
// Steps inserts and pops through the heap one level at a time, using one
// key comparator and the two memory read ports.
// ----------------------------------------------------------------------------
module emh_sequencer #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int CW    = 11,
  parameter int SW    = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_kind,
  input  logic [emh_pkg::KEY_W-1:0]  in_key,
  input  logic [emh_pkg::IN_TAG_W-1:0] in_tag,
  output logic                       res_valid,
  input  logic                       res_ready,
  output emh_pkg::result_t           res,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [emh_pkg::KEY_W+SW-1:0] mem_wdata,
  output logic [AW-1:0]              mem_raddr_a,
  output logic [AW-1:0]              mem_raddr_b,
  input  logic [emh_pkg::KEY_W+SW-1:0] mem_rdata_a,
  input  logic [emh_pkg::KEY_W+SW-1:0] mem_rdata_b
);

  localparam int EW = emh_pkg::KEY_W + SW;
  localparam int LW = AW + 2;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_POP_RD = 7'b0000010,
    S_DN_RD  = 7'b0000100,
    S_DN_CMP = 7'b0001000,
    S_UP_RD  = 7'b0010000,
    S_UP_CMP = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [AW-1:0]               pos_r, pos_nxt;
  logic [EW-1:0]               item_r, item_nxt;
  logic [EW-1:0]               top_r, top_nxt;
  logic [emh_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                        res_valid_r, res_valid_nxt;
  emh_pkg::result_t            res_r, res_nxt;

  logic [LW-1:0]   left_idx, right_idx, count_ext;
  logic [AW-1:0]   parent_idx, pick_idx;
  logic [emh_pkg::KEY_W-1:0] cmp_lhs, cmp_rhs;
  logic            key_lt;
  logic [31:0]     fill_ext;
  logic            accept, load;

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign load       = (state_r == S_DONE) && (!res_valid_r || res_ready);
  assign left_idx   = {1'b0, pos_r, 1'b1};
  assign right_idx  = {1'b0, pos_r, 1'b1} + LW'(1);
  assign count_ext  = LW'(count_r);
  assign parent_idx = (pos_r - AW'(1)) >> 1;
  assign cmp_lhs    = (state_r == S_UP_CMP) ? item_r[emh_pkg::KEY_W-1:0] :
                      mem_rdata_a[emh_pkg::KEY_W-1:0];
  assign cmp_rhs    = (state_r == S_UP_CMP) ? mem_rdata_a[emh_pkg::KEY_W-1:0] :
                      mem_rdata_b[emh_pkg::KEY_W-1:0];
  assign key_lt     = (cmp_lhs < cmp_rhs);
  assign pick_idx   = key_lt ? left_idx[AW-1:0] : right_idx[AW-1:0];
  assign fill_ext   = 32'(count_r);
  assign res_valid  = res_valid_r;
  assign res        = res_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    item_nxt      = item_r;
    top_nxt       = top_r;
    status_nxt    = status_r;
    res_valid_nxt = res_valid_r;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = item_r;
    mem_raddr_a   = parent_idx;
    mem_raddr_b   = parent_idx;

    if (res_valid_r && res_ready) begin
      res_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          top_nxt    = '0;
          status_nxt = emh_pkg::ST_OK;
          if (in_kind == emh_pkg::KIND_INSERT) begin
            if (count_r >= CW'(DEPTH)) begin
              status_nxt = emh_pkg::ST_OVERFLOW;
              state_nxt  = S_DONE;
            end else begin
              item_nxt  = {in_tag[SW-1:0], in_key};
              pos_nxt   = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
              state_nxt = S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = emh_pkg::ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              mem_raddr_a = '0;
              mem_raddr_b = AW'(count_r - CW'(1));
              state_nxt   = S_POP_RD;
            end
          end
        end
      end
      S_POP_RD: begin
        top_nxt   = mem_rdata_a;
        item_nxt  = mem_rdata_b;
        pos_nxt   = '0;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        mem_raddr_a = left_idx[AW-1:0];
        mem_raddr_b = right_idx[AW-1:0];
        if (right_idx < count_ext) begin
          state_nxt = S_DN_CMP;
        end else if (right_idx == count_ext) begin
          mem_we    = 1'b1;
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_UP_RD;
        end
      end
      S_DN_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = (pick_idx == left_idx[AW-1:0]) ? mem_rdata_a : mem_rdata_b;
        pos_nxt   = pick_idx;
        state_nxt = S_DN_RD;
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (key_lt) begin
          mem_wdata = mem_rdata_a;
          pos_nxt   = parent_idx;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          res_valid_nxt    = 1'b1;
          res_nxt.time_key = top_r[emh_pkg::KEY_W-1:0];
          res_nxt.tag      = emh_pkg::IN_TAG_W'(top_r[EW-1:emh_pkg::KEY_W]);
          res_nxt.status   = status_r;
          res_nxt.fill     = fill_ext[emh_pkg::FILL_W-1:0];
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    item_r   <= item_nxt;
    top_r    <= top_nxt;
    status_r <= status_nxt;
    res_r    <= res_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("Entry count exceeds heap depth.");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) ||
              (count_r == $past(count_r) - CW'(1))))
    else $error("Entry count moved by more than one.");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("Heap memory written while idle.");

  a_descent_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DN_CMP) |-> (LW'(pick_idx) < count_ext))
    else $error("Hole moved beyond the last entry.");

endmodule

/* sim/emh_checker.sv */
// ----------------------------------------------------------------------------
// Event min-heap result checker
// Watches the request and result streams of the event min-heap unit. It keeps
// its own copy of the heap, works out the result of each accepted request,
// and compares every accepted result with the oldest one still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module emh_checker #(
  parameter int HEAP_DEPTH = 1024,
  parameter int TAG_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // time_key[31:0], tag[47:32]
  input  logic        in_tuser,   // kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,  // out_time[31:0], out_tag[47:32], fill[58:48], zero
  input  logic [1:0]  out_tuser,  // status
  output int          mismatches,
  output int          outstanding
);

  localparam logic [emh_pkg::IN_TAG_W-1:0] TAG_MASK =
    (TAG_BITS >= emh_pkg::IN_TAG_W) ? {emh_pkg::IN_TAG_W{1'b1}} :
                                      emh_pkg::IN_TAG_W'((1 << TAG_BITS) - 1);

  logic [emh_pkg::KEY_W-1:0]    slot_key [HEAP_DEPTH];
  logic [emh_pkg::IN_TAG_W-1:0] slot_tag [HEAP_DEPTH];
  int                           held;
  emh_pkg::result_t             pending_results [$];

  function automatic void climb_place(int pos, logic [emh_pkg::KEY_W-1:0] key,
                                      logic [emh_pkg::IN_TAG_W-1:0] tag);
    int parent;
    while (pos != 0) begin
      parent = (pos - 1) / 2;
      if (!(slot_key[parent] > key)) break;
      slot_key[pos] = slot_key[parent];
      slot_tag[pos] = slot_tag[parent];
      pos = parent;
    end
    slot_key[pos] = key;
    slot_tag[pos] = tag;
  endfunction

  function automatic emh_pkg::result_t apply_request(logic kind,
                                                     logic [emh_pkg::KEY_W-1:0] key,
                                                     logic [emh_pkg::IN_TAG_W-1:0] tag);
    emh_pkg::result_t             res;
    int                           n;
    int                           hole;
    int                           left;
    int                           pick;
    logic [emh_pkg::KEY_W-1:0]    last_key;
    logic [emh_pkg::IN_TAG_W-1:0] last_tag;
    res = '0;
    if (kind == emh_pkg::KIND_INSERT) begin
      if (held >= HEAP_DEPTH) begin
        res.status = emh_pkg::ST_OVERFLOW;
      end else begin
        held++;
        climb_place(held - 1, key, tag & TAG_MASK);
      end
    end else if (held == 0) begin
      res.status = emh_pkg::ST_EMPTY;
    end else begin
      n            = held;
      hole         = 0;
      res.time_key = slot_key[0];
      res.tag      = slot_tag[0];
      last_key     = slot_key[n - 1];
      last_tag     = slot_tag[n - 1];
      while (2 * hole + 2 < n) begin
        left = 2 * hole + 1;
        pick = (slot_key[left] < slot_key[left + 1]) ? left : left + 1;
        slot_key[hole] = slot_key[pick];
        slot_tag[hole] = slot_tag[pick];
        hole = pick;
      end
      if (2 * hole + 2 == n) begin
        slot_key[hole] = last_key;
        slot_tag[hole] = last_tag;
      end else begin
        climb_place(hole, last_key, last_tag);
      end
      held = n - 1;
    end
    res.fill = held[emh_pkg::FILL_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    emh_pkg::result_t             want;
    logic [emh_pkg::KEY_W-1:0]    got_time;
    logic [emh_pkg::IN_TAG_W-1:0] got_tag;
    logic [emh_pkg::FILL_W-1:0]   got_fill;
    logic [4:0]                   got_pad;
    if (!rst_n) begin
      held = 0;
      pending_results.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(apply_request(in_tuser, in_tdata[31:0],
                                                in_tdata[47:32]));
      end
      if (out_tvalid && out_tready) begin
        got_time = out_tdata[31:0];
        got_tag  = out_tdata[47:32];
        got_fill = out_tdata[58:48];
        got_pad  = out_tdata[63:59];
        if (pending_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result with no request waiting: time=%h tag=%h status=%0d fill=%0d",
                     $realtime, got_time, got_tag, out_tuser, got_fill);
          end
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got_time !== want.time_key || got_tag !== want.tag ||
              out_tuser !== want.status || got_fill !== want.fill || got_pad !== '0) begin
            if (mismatches < 10) begin
              $display("%0t: expected time=%h tag=%h status=%0d fill=%0d",
                       $realtime, want.time_key, want.tag, want.status, want.fill);
              $display("%0t:   actual time=%h tag=%h status=%0d fill=%0d pad=%h",
                       $realtime, got_time, got_tag, out_tuser, got_fill, got_pad);
            end
            mismatches++;
          end
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Event min-heap unit testbench
// Drives insert and pop requests into the heap with random gaps on both
// streams: a directed opening, then growth, a fill to capacity with overflow
// attempts, and a drain past empty. The checker module predicts and compares
// every result; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH = 1024;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  int          mismatches;
  int          outstanding;
  int          heap_level;
  bit          steady;

  event_min_heap_unit #(.HEAP_DEPTH(DEPTH), .TAG_BITS(16)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  emh_checker #(.HEAP_DEPTH(DEPTH), .TAG_BITS(16)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [emh_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(logic kind, logic [emh_pkg::KEY_W-1:0] key,
                              logic [emh_pkg::IN_TAG_W-1:0] tag);
    int gap;
    bit taken;
    if ($urandom_range(0, 99) == 0) steady = !steady;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {tag, key};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    if (kind == emh_pkg::KIND_INSERT && heap_level < DEPTH) heap_level++;
    if (kind == emh_pkg::KIND_POP && heap_level > 0) heap_level--;
  endtask

  task automatic send_mixed(int insert_pct);
    logic kind;
    kind = ($urandom_range(0, 99) < insert_pct) ? emh_pkg::KIND_INSERT : emh_pkg::KIND_POP;
    send_request(kind, pick_key(), 16'($urandom_range(0, 65535)));
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("event_min_heap_unit test failed");
    $finish;
  end

  initial begin : result_sink
    int  gap;
    bit  seen;
    out_tready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        seen = out_tvalid;
        @(posedge clk);
      end while (!seen);
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= emh_pkg::KIND_INSERT;
    heap_level = 0;
    steady     = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(emh_pkg::KIND_POP,    '1,            16'hFFFF);
    send_request(emh_pkg::KIND_INSERT, '0,            16'h0000);
    send_request(emh_pkg::KIND_INSERT, '1,            16'hFFFF);
    send_request(emh_pkg::KIND_INSERT, '1,            16'h0001);
    send_request(emh_pkg::KIND_INSERT, 32'd5,         16'h0002);
    send_request(emh_pkg::KIND_INSERT, 32'd5,         16'h0003);
    send_request(emh_pkg::KIND_INSERT, 32'd5,         16'h0004);
    send_request(emh_pkg::KIND_INSERT, '0,            16'h0005);
    send_request(emh_pkg::KIND_INSERT, 32'h0001_8000, 16'h0006);
    repeat (9) send_request(emh_pkg::KIND_POP, $urandom, 16'($urandom_range(0, 65535)));
    send_request(emh_pkg::KIND_INSERT, 32'd1,         16'hA5A5);
    send_request(emh_pkg::KIND_INSERT, 32'd1,         16'h5A5A);
    send_request(emh_pkg::KIND_INSERT, 32'd1,         16'h00FF);
    send_request(emh_pkg::KIND_INSERT, 32'd2,         16'hFF00);
    send_request(emh_pkg::KIND_INSERT, 32'd1,         16'h1234);
    repeat (6) send_request(emh_pkg::KIND_POP, '0, '0);

    repeat (50) send_mixed(75);
    wait_results_drained();
    repeat (50) send_mixed(75);

    while (heap_level < DEPTH) send_mixed(97);
    wait_results_drained();
    repeat (24) send_mixed(60);

    while (heap_level > 0) send_mixed(3);
    repeat (3) send_request(emh_pkg::KIND_POP, $urandom, 16'($urandom_range(0, 65535)));

    in_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (40) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("event_min_heap_unit test passed");
    end else begin
      $display("event_min_heap_unit test failed");
    end
    $finish;
  end

endmodule
